// ===== src/hac_pkg.sv =====
// hac_pkg: sizes and command / status codes of the heap allocation checker.
// No dependencies; imported by heap_allocation_checker.
package hac_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int ADDR_W        = 64;
    localparam int CMD_W         = 3;
    localparam int ST_W          = 4;

    localparam logic [CMD_W-1:0] CMD_TRACE_ON  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TRACE_OFF = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REL       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RDONE     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_REPORT    = 3'd6;

    localparam logic [ST_W-1:0] ST_IGNORED      = 4'd0;
    localparam logic [ST_W-1:0] ST_NEW          = 4'd1;
    localparam logic [ST_W-1:0] ST_REVIVED      = 4'd2;
    localparam logic [ST_W-1:0] ST_LIVE_DUP     = 4'd3;
    localparam logic [ST_W-1:0] ST_NULL_ALLOC   = 4'd4;
    localparam logic [ST_W-1:0] ST_FREED        = 4'd5;
    localparam logic [ST_W-1:0] ST_DOUBLE_FREE  = 4'd6;
    localparam logic [ST_W-1:0] ST_UNKNOWN_FREE = 4'd7;
    localparam logic [ST_W-1:0] ST_REL_OK       = 4'd8;
    localparam logic [ST_W-1:0] ST_REL_MISSING  = 4'd9;
    localparam logic [ST_W-1:0] ST_REALLOC_LIVE = 4'd10;
    localparam logic [ST_W-1:0] ST_LEAK         = 4'd11;
    localparam logic [ST_W-1:0] ST_TABLE_FULL   = 4'd12;
    localparam logic [ST_W-1:0] ST_REPORT_DONE  = 4'd13;

endpackage

// ===== src/heap_allocation_checker.sv =====
// heap_allocation_checker: heap event tracker with an address table in a
// synchronous RAM, freed marks in flops and a sorted leak report.
// Depends on hac_pkg.

// Addresses live in a one-port-read, one-port-write RAM of TABLE_ENTRIES words
// that fills in slot order; every lookup walks the used entries one per cycle
// through the registered read port. Trace commands, unused codes and events
// while tracing is off emit their result without a table walk. An allocation,
// free or realloc event with tracing on walks the used entries until the
// address is found or all used entries are read. A leak report runs one
// table walk per leaked entry plus one more for the done marker, each walk
// followed by S_EMIT, which loads its result into the output register.
// The input side stalls while an item is at work; a finished result waits in
// the output register without holding up the next item. No clearing pass
// after reset.
module heap_allocation_checker
    import hac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [ADDR_W-1:0] i_block_addr,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [ADDR_W-1:0] o_report_addr,
    output logic              o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_LEAK,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [CMD_W-1:0]    r_cmd;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_tracing;
    logic [CNT_W-1:0]    r_used;
    logic [TABLE_ENTRIES-1:0] r_freed;

    // table walk
    logic [CNT_W-1:0]    r_idx;
    logic                r_pend;
    logic [IDX_W-1:0]    r_pend_idx;

    // leak search
    logic [ADDR_W-1:0]   r_prev;
    logic                r_have_prev;
    logic [ADDR_W-1:0]   r_best;
    logic                r_have_best;

    // pending result
    logic [ST_W-1:0]     r_res_status;
    logic [ADDR_W-1:0]   r_res_addr;
    logic                r_res_last;
    logic                r_res_more;

    // output register
    logic                r_out_valid;
    logic [ST_W-1:0]     r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                r_out_last;

    logic [ADDR_W-1:0]   mem [TABLE_ENTRIES];
    logic [ADDR_W-1:0]   r_q;

    logic                w_issue;
    logic                w_match;
    logic                w_hit_freed;
    logic                w_full;
    logic                w_look_done;
    logic                w_pass_end;
    logic                w_cand;
    logic                w_out_free;
    logic                w_mem_we;
    logic [ST_W-1:0]     w_dec_status;
    logic                w_set_fr;
    logic                w_clr_fr;
    logic                w_ins;

    assign w_issue     = ((r_state == S_LOOK) || (r_state == S_LEAK)) && (r_idx < r_used);
    assign w_match     = r_pend && (r_q == r_addr);
    assign w_hit_freed = r_freed[r_pend_idx];
    assign w_full      = (r_used == CNT_W'(TABLE_ENTRIES));
    assign w_look_done = (r_state == S_LOOK) && (w_match || (r_idx >= r_used));
    assign w_pass_end  = (r_state == S_LEAK) && !r_pend && (r_idx >= r_used);
    assign w_cand      = r_pend && !r_freed[r_pend_idx]
                         && (!r_have_prev || (r_q > r_prev))
                         && (!r_have_best || (r_q < r_best));
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_mem_we    = w_look_done && w_ins;

    // outcome of a finished lookup; w_match means the entry was found
    always_comb begin
        w_dec_status = ST_IGNORED;
        w_set_fr     = 1'b0;
        w_clr_fr     = 1'b0;
        w_ins        = 1'b0;
        unique case (r_cmd)
            CMD_ALLOC: begin
                if (r_addr == '0) begin
                    w_dec_status = ST_NULL_ALLOC;
                end else if (w_match) begin
                    if (w_hit_freed) begin
                        w_clr_fr     = 1'b1;
                        w_dec_status = ST_REVIVED;
                    end else begin
                        w_dec_status = ST_LIVE_DUP;
                    end
                end else if (!w_full) begin
                    w_ins        = 1'b1;
                    w_dec_status = ST_NEW;
                end else begin
                    w_dec_status = ST_TABLE_FULL;
                end
            end
            CMD_FREE: begin
                if (!w_match) begin
                    w_dec_status = ST_UNKNOWN_FREE;
                end else if (w_hit_freed) begin
                    w_dec_status = ST_DOUBLE_FREE;
                end else begin
                    w_set_fr     = 1'b1;
                    w_dec_status = ST_FREED;
                end
            end
            CMD_REL: begin
                if (w_match) begin
                    w_set_fr     = 1'b1;
                    w_dec_status = ST_REL_OK;
                end else begin
                    w_dec_status = ST_REL_MISSING;
                end
            end
            CMD_RDONE: begin
                if ((r_addr == '0) || !w_match) begin
                    w_dec_status = ST_IGNORED;
                end else if (w_hit_freed) begin
                    w_clr_fr     = 1'b1;
                    w_dec_status = ST_REVIVED;
                end else begin
                    w_dec_status = ST_REALLOC_LIVE;
                end
            end
            default: begin
                w_dec_status = ST_IGNORED;
            end
        endcase
    end

    // address RAM: new entries go to slot r_used, reads are registered
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_used[IDX_W-1:0]] <= r_addr;
        end
        if (w_issue) begin
            r_q <= mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tracing   <= 1'b0;
            r_used      <= '0;
            r_freed     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_have_prev <= 1'b0;
            r_have_best <= 1'b0;
            r_res_more  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // S_EMIT reloads the output register itself
            if (r_out_valid && !i_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            if (w_issue) begin
                r_pend     <= 1'b1;
                r_pend_idx <= r_idx[IDX_W-1:0];
                r_idx      <= r_idx + CNT_W'(1);
            end else begin
                r_pend <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd      <= i_cmd;
                        r_addr     <= i_block_addr;
                        r_idx      <= '0;
                        r_res_last <= 1'b1;
                        r_res_more <= 1'b0;
                        unique case (i_cmd) inside
                            CMD_TRACE_ON, CMD_TRACE_OFF: begin
                                r_tracing    <= (i_cmd == CMD_TRACE_ON);
                                r_res_status <= ST_IGNORED;
                                r_res_addr   <= '0;
                                r_state      <= S_EMIT;
                            end
                            CMD_ALLOC, CMD_FREE, CMD_REL, CMD_RDONE: begin
                                if (r_tracing) begin
                                    r_state <= S_LOOK;
                                end else begin
                                    r_res_status <= ST_IGNORED;
                                    r_res_addr   <= i_block_addr;
                                    r_state      <= S_EMIT;
                                end
                            end
                            CMD_REPORT: begin
                                r_have_prev <= 1'b0;
                                r_have_best <= 1'b0;
                                r_state     <= S_LEAK;
                            end
                            default: begin
                                r_res_status <= ST_IGNORED;
                                r_res_addr   <= '0;
                                r_state      <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_LOOK: begin
                    if (w_look_done) begin
                        if (w_set_fr) begin
                            r_freed[r_pend_idx] <= 1'b1;
                        end
                        if (w_clr_fr) begin
                            r_freed[r_pend_idx] <= 1'b0;
                        end
                        if (w_ins) begin
                            r_freed[r_used[IDX_W-1:0]] <= 1'b0;
                            r_used <= r_used + CNT_W'(1);
                        end
                        r_res_status <= w_dec_status;
                        r_res_addr   <= r_addr;
                        r_res_last   <= 1'b1;
                        r_res_more   <= 1'b0;
                        r_state      <= S_EMIT;
                    end
                end
                S_LEAK: begin
                    // each pass finds the smallest unfreed address above the last one
                    if (w_cand) begin
                        r_best      <= r_q;
                        r_have_best <= 1'b1;
                    end
                    if (w_pass_end) begin
                        if (r_have_best) begin
                            r_res_status <= ST_LEAK;
                            r_res_addr   <= r_best;
                            r_res_last   <= 1'b0;
                            r_res_more   <= 1'b1;
                            r_prev       <= r_best;
                            r_have_prev  <= 1'b1;
                        end else begin
                            r_res_status <= ST_REPORT_DONE;
                            r_res_addr   <= '0;
                            r_res_last   <= 1'b1;
                            r_res_more   <= 1'b0;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_addr   <= r_res_addr;
                        r_out_last   <= r_res_last;
                        if (r_res_more) begin
                            r_idx       <= '0;
                            r_have_best <= 1'b0;
                            r_state     <= S_LEAK;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_report_addr = r_out_addr;
    assign o_last        = r_out_last;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("used entry count beyond table size");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |=> (r_used == $past(r_used) + CNT_W'(1)))
        else $error("insert did not advance used entry count");

    a_leak_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pass_end && r_have_best && r_have_prev) |-> (r_best > r_prev))
        else $error("leak addresses not ascending");

    a_last_only_leak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_status == ST_LEAK))
        else $error("non-final result that is not a leak item");
`endif

endmodule
